>>> hw/rtl/page_frame_first_fit_allocator_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef PAGE_FRAME_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, held off during reset
`define PFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, held off during reset
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

>>> hw/rtl/pfa_pkg.sv
package pfa_pkg;

	// default geometry
	localparam int NUM_FRAMES_DEF  = 8;
	localparam int FRAME_BYTES_DEF = 32;

	// request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NOOP  = 2'd1;
	localparam logic [1:0] STATUS_OOM   = 2'd2;
	localparam logic [1:0] STATUS_FAULT = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

>>> hw/rtl/pfa_req_if.sv
interface pfa_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] request_bytes;
	logic [7:0]  free_address;
	logic        address_is_null;

	modport source (
		output valid, op, request_bytes, free_address, address_is_null,
		input  ready
	);
	modport sink (
		input  valid, op, request_bytes, free_address, address_is_null,
		output ready
	);
endinterface

>>> hw/rtl/pfa_rsp_if.sv
interface pfa_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] granted_address;

	modport source (
		output valid, status, granted_address,
		input  ready
	);
	modport sink (
		input  valid, status, granted_address,
		output ready
	);
endinterface

>>> hw/rtl/pfa_ctrl.sv
`include "page_frame_first_fit_allocator_macros.svh"

module pfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output pfa_pkg::cmd_t cmd
);

	pfa_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = pfa_pkg::ST_EXEC;
				end
			end
			pfa_pkg::ST_EXEC: begin
				// result slot free, or its beat leaves this cycle
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = pfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfa_pkg::ST_IDLE;
			end
		endcase
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`PFA_ASSERT_NEXT(a_exec_gives_beat, clk, arst_n, cmd.exec, out_valid_q)
	`PFA_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.exec, !out_valid_q || out_ready)
	`PFA_ASSERT_NEXT(a_load_to_exec, clk, arst_n, cmd.load, state_q == pfa_pkg::ST_EXEC)

endmodule

>>> hw/rtl/pfa_datapath.sv
`include "page_frame_first_fit_allocator_macros.svh"

module pfa_datapath #(
	parameter int NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = pfa_pkg::FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pfa_pkg::cmd_t cmd,
	input  logic          op,
	input  logic [15:0]   request_bytes,
	input  logic [7:0]    free_address,
	input  logic          address_is_null,
	output logic [1:0]    status,
	output logic [7:0]    granted_address
);

	localparam int LEN_W = $clog2(NUM_FRAMES + 1);

	// request register
	logic                  op_q;
	logic                  null_q;
	logic [NUM_FRAMES:0]   therm_q, therm_d;
	logic [LEN_W-1:0]      need_q, need_d;
	logic [NUM_FRAMES-1:0] hit_q, hit_d;

	// allocation state
	logic [NUM_FRAMES-1:0] reserved_q, reserved_d;
	logic [LEN_W-1:0]      run_len_q [NUM_FRAMES];
	logic [LEN_W-1:0]      run_len_d [NUM_FRAMES];

	// search and release
	logic [NUM_FRAMES-1:0] fits, first, set_mask, rel_mask;
	logic                  found;
	logic                  sel_res;
	logic [LEN_W-1:0]      sel_len;
	logic [7:0]            grant_addr;

	// result
	logic [1:0] status_d, status_q;
	logic [7:0] addr_d, addr_q;

	// size thermometer: bit j set when the request spans more than j frames
	always_comb begin
		for (int j = 0; j <= NUM_FRAMES; j++) begin
			therm_d[j] = 32'(request_bytes) > 32'(j * FRAME_BYTES);
		end
		need_d = '0;
		for (int j = NUM_FRAMES; j >= 1; j--) begin
			if (!therm_d[j]) need_d = LEN_W'(j);
		end
		// aligned address inside the pool hits exactly one frame
		for (int f = 0; f < NUM_FRAMES; f++) begin
			hit_d[f] = 32'(free_address) == 32'(f * FRAME_BYTES);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			null_q  <= address_is_null;
			therm_q <= therm_d;
			need_q  <= need_d;
			hit_q   <= hit_d;
		end
	end

	// start s fits when the run stays inside the pool and covers no reserved frame
	always_comb begin
		for (int s = 0; s < NUM_FRAMES; s++) begin
			fits[s] = !therm_q[NUM_FRAMES - s];
			for (int k = s; k < NUM_FRAMES; k++) begin
				if (reserved_q[k] && therm_q[k - s]) fits[s] = 1'b0;
			end
		end
	end

	// lowest fitting start wins
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int s = 0; s < NUM_FRAMES; s++) begin
			first[s] = fits[s] && !seen;
			seen     = seen || fits[s];
		end
	end

	assign found = |fits;

	// frames to reserve, and aligned start address
	always_comb begin
		set_mask   = '0;
		grant_addr = '0;
		for (int s = 0; s < NUM_FRAMES; s++) begin
			if (first[s]) grant_addr = grant_addr | 8'(s * FRAME_BYTES);
			for (int k = s; k < NUM_FRAMES; k++) begin
				if (first[s] && therm_q[k - s]) set_mask[k] = 1'b1;
			end
		end
	end

	// frames to release, bounded at the last frame
	always_comb begin
		rel_mask = '0;
		sel_len  = '0;
		sel_res  = |(hit_q & reserved_q);
		for (int f = 0; f < NUM_FRAMES; f++) begin
			if (hit_q[f]) sel_len = sel_len | run_len_q[f];
			for (int k = f; k < NUM_FRAMES; k++) begin
				if (hit_q[f] && (LEN_W'(k - f) < run_len_q[f])) rel_mask[k] = 1'b1;
			end
		end
	end

	// result and next state
	always_comb begin
		status_d   = pfa_pkg::STATUS_OK;
		addr_d     = '0;
		reserved_d = reserved_q;
		run_len_d  = run_len_q;
		if (op_q == pfa_pkg::OP_ALLOC) begin
			if (!therm_q[0]) begin
				status_d = pfa_pkg::STATUS_NOOP;
			end else if (therm_q[NUM_FRAMES] || !found) begin
				status_d = pfa_pkg::STATUS_OOM;
			end else begin
				addr_d     = grant_addr;
				reserved_d = reserved_q | set_mask;
				for (int s = 0; s < NUM_FRAMES; s++) begin
					if (first[s]) run_len_d[s] = need_q;
				end
			end
		end else begin
			if (null_q) begin
				status_d = pfa_pkg::STATUS_NOOP;
			end else if (!sel_res || sel_len == '0) begin
				// unaligned, outside the pool, or not a run start
				status_d = pfa_pkg::STATUS_FAULT;
			end else begin
				reserved_d = reserved_q & ~rel_mask;
				for (int f = 0; f < NUM_FRAMES; f++) begin
					if (hit_q[f]) run_len_d[f] = '0;
				end
			end
		end
	end

	// bitmap and run lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
			for (int f = 0; f < NUM_FRAMES; f++) begin
				run_len_q[f] <= '0;
			end
		end else if (cmd.exec) begin
			reserved_q <= reserved_d;
			run_len_q  <= run_len_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			addr_q   <= addr_d;
		end
	end

	assign status          = status_q;
	assign granted_address = addr_q;

	`PFA_ASSERT_IMPL(a_len_implies_reserved, clk, arst_n, run_len_q[0] != '0, reserved_q[0])
	`PFA_ASSERT_NEXT(a_fault_keeps_map, clk, arst_n, cmd.exec && status_d == pfa_pkg::STATUS_FAULT, reserved_q == $past(reserved_q))

endmodule

>>> hw/rtl/page_frame_first_fit_allocator.sv
// A request beat accepted in the idle state is registered and executed in the execute
// state, which registers its result beat. The controller holds one request at a time and
// takes no new one until it is executed; the run search is combinational logic.
// A stalled result beat holds the next request in the execute state.
// Reset (arst_n low, asynchronous): every frame free, all run lengths zero, no beat pending.
module page_frame_first_fit_allocator #(
	parameter int NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = pfa_pkg::FRAME_BYTES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pfa_req_if.sink   req,
	pfa_rsp_if.source rsp
);

	pfa_pkg::cmd_t cmd;

	// sequencing and result handshake
	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// bitmap, search and result
	pfa_datapath #(
		.NUM_FRAMES  (NUM_FRAMES),
		.FRAME_BYTES (FRAME_BYTES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (req.op),
		.request_bytes   (req.request_bytes),
		.free_address    (req.free_address),
		.address_is_null (req.address_is_null),
		.status          (rsp.status),
		.granted_address (rsp.granted_address)
	);

endmodule
